@@ sv/fisr_pkg.sv @@
package fisr_pkg;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [31:0] MagicSeed = 32'h5F37_59DF;
  localparam logic [31:0] FpHalf = 32'h3F00_0000;
  localparam logic [31:0] FpThreeHalves = 32'h3FC0_0000;
  localparam logic [7:0] ExpMax = 8'hFF;

  // Count leading zeros of a 48-bit word (48 when all zero).
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    logic hit;
    n = 6'd48;
    hit = 1'b0;
    for (int i = 47; i >= 0; i--) begin
      if (!hit && v[i]) begin
        n = 6'(47 - i);
        hit = 1'b1;
      end
    end
    return n;
  endfunction

  // Round to nearest even and pack; fld is the biased exponent, zero for subnormal.
  function automatic logic [31:0] round_pack(input logic sgn, input logic [9:0] fld,
                                             input logic [22:0] mant, input logic g,
                                             input logic st);
    logic rnd;
    logic [30:0] mag;
    rnd = g & (st | mant[0]);
    if (fld >= 10'd255) begin
      mag = {ExpMax, 23'd0};
    end else begin
      mag = {fld[7:0], mant} + 31'(rnd);
    end
    return {sgn, mag};
  endfunction

endpackage

@@ sv/fast_inverse_sqrt_top.sv @@
// Channel   Direction  Handshake            Payload
// in        sink       valid_i / stall_o    value_bits_i  (binary32)
// out       source     valid_o / stall_i    result_bits_o (binary32)
//
// One beat can enter every cycle while no finished beat is held under stall_i.
// Path: x*0.5, *y, *y (4-stage multipliers), 1.5-t (5-stage adder), y*t.
// Reset clears the valid bits and the output register of each unit; the
// other datapath registers are not reset.
// The whole pipeline holds while a finished beat waits at the output under
// stall_i; otherwise it advances every cycle, bubbles included.
module fast_inverse_sqrt_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] value_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] result_bits_o
);

  localparam int Lat = 21;

  logic           en;
  logic [Lat-1:0] vld_q;
  logic [31:0]    seed;
  logic [31:0]    y_q [0:16];
  logic [31:0]    half, hy, hyy, corr, res;

  // advance unless the output beat is held
  assign en = !(vld_q[Lat-1] && stall_i);
  assign stall_o = !en;

  // first estimate: magic constant minus the arithmetic half of the pattern
  assign seed = fisr_pkg::MagicSeed - {value_bits_i[31], value_bits_i[31:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], valid_i};
    end
  end

  // carry the estimate alongside the multiplier chain
  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q[0] <= seed;
      for (int i = 1; i < 17; i++) begin
        y_q[i] <= y_q[i-1];
      end
    end
  end

  fisr_fmul u_mul_half (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (value_bits_i), .b_i (fisr_pkg::FpHalf), .p_o (half)
  );

  fisr_fmul u_mul_hy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (half), .b_i (y_q[3]), .p_o (hy)
  );

  fisr_fmul u_mul_hyy (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (hy), .b_i (y_q[7]), .p_o (hyy)
  );

  // 1.5 - t as 1.5 + (-t)
  fisr_fadd u_sub (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (fisr_pkg::FpThreeHalves), .b_i ({~hyy[31], hyy[30:0]}), .s_o (corr)
  );

  // NaN results leave the multiplier already in canonical form
  fisr_fmul u_mul_out (
    .clk_i (clk_i), .rst_ni (rst_ni), .en_i (en),
    .a_i (y_q[16]), .b_i (corr), .p_o (res)
  );

  assign valid_o = vld_q[Lat-1];
  assign result_bits_o = res;

endmodule

@@ sv/fisr_fmul.sv @@
module fisr_fmul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  // stage 1: unpack, multiply
  logic [7:0]  ea, eb, eaa, ebb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
  logic [47:0] prod_d, prod_q, prod2_q;
  logic signed [10:0] e0_d, e0_q, e02_q;
  logic        spec_d, spec_q, spec2_q, spec3_q;
  logic [31:0] sval_d, sval_q, sval2_q, sval3_q;
  logic        sgn_q, sgn2_q, sgn3_q;
  logic [5:0]  lz_q;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    eaa = (ea == 8'd0) ? 8'd1 : ea;
    ebb = (eb == 8'd0) ? 8'd1 : eb;
    a_nan = (ea == fisr_pkg::ExpMax) && (a_i[22:0] != 23'd0);
    b_nan = (eb == fisr_pkg::ExpMax) && (b_i[22:0] != 23'd0);
    a_inf = (ea == fisr_pkg::ExpMax) && (a_i[22:0] == 23'd0);
    b_inf = (eb == fisr_pkg::ExpMax) && (b_i[22:0] == 23'd0);
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    sgn = a_i[31] ^ b_i[31];
    prod_d = {(ea != 8'd0), a_i[22:0]} * {(eb != 8'd0), b_i[22:0]};
    e0_d = $signed({3'b000, eaa}) + $signed({3'b000, ebb}) - 11'sd126;
    spec_d = a_nan | b_nan | a_inf | b_inf | a_zero | b_zero;
    if (a_nan | b_nan | (a_inf & b_zero) | (a_zero & b_inf)) begin
      sval_d = fisr_pkg::CanonNan;
    end else if (a_inf | b_inf) begin
      sval_d = {sgn, fisr_pkg::ExpMax, 23'd0};
    end else begin
      sval_d = {sgn, 31'd0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      e0_q <= e0_d;
      spec_q <= spec_d;
      sval_q <= sval_d;
      sgn_q <= sgn;
    end
  end

  // stage 2: leading zero count
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lz_q <= fisr_pkg::lzc48(prod_q);
      prod2_q <= prod_q;
      e02_q <= e0_q;
      spec2_q <= spec_q;
      sval2_q <= sval_q;
      sgn2_q <= sgn_q;
    end
  end

  // stage 3: normalize, or denormalize into the subnormal range
  logic signed [10:0] diff, amt;
  logic [47:0] sh;
  logic        rst_st;
  logic [9:0]  fld_d, fld_q;
  logic [22:0] mant_q;
  logic        g_q, st_q;

  always_comb begin
    diff = e02_q - $signed({5'd0, lz_q});
    amt = 11'sd1 - e02_q;
    rst_st = 1'b0;
    if (diff >= 11'sd1) begin
      sh = prod2_q << lz_q;
      fld_d = diff[9:0];
    end else if (e02_q >= 11'sd1) begin
      sh = prod2_q << 6'(e02_q - 11'sd1);
      fld_d = 10'd0;
    end else if (amt > 11'sd47) begin
      sh = 48'd0;
      rst_st = prod2_q != 48'd0;
      fld_d = 10'd0;
    end else begin
      sh = prod2_q >> amt[5:0];
      rst_st = (prod2_q & ((48'd1 << amt[5:0]) - 48'd1)) != 48'd0;
      fld_d = 10'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mant_q <= sh[46:24];
      g_q <= sh[23];
      st_q <= (sh[22:0] != 23'd0) | rst_st;
      fld_q <= fld_d;
      spec3_q <= spec2_q;
      sval3_q <= sval2_q;
      sgn3_q <= sgn2_q;
    end
  end

  // stage 4: round and pack
  logic [31:0] p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= 32'd0;
    end else if (en_i) begin
      p_q <= spec3_q ? sval3_q : fisr_pkg::round_pack(sgn3_q, fld_q, mant_q, g_q, st_q);
    end
  end

  assign p_o = p_q;

endmodule

@@ sv/fisr_fadd.sv @@
module fisr_fadd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);

  // stage 1: unpack, order by magnitude
  logic [7:0]  ea, eb;
  logic        a_nan, b_nan, a_inf, b_inf, a_big;
  logic        spec_d;
  logic [31:0] sval_d;
  logic [23:0] ml_q, ms_q;
  logic [7:0]  el_q, d_q;
  logic        sub_q, sgn_q, spec_q;
  logic [31:0] sval_q;

  always_comb begin
    ea = a_i[30:23];
    eb = b_i[30:23];
    a_nan = (ea == fisr_pkg::ExpMax) && (a_i[22:0] != 23'd0);
    b_nan = (eb == fisr_pkg::ExpMax) && (b_i[22:0] != 23'd0);
    a_inf = (ea == fisr_pkg::ExpMax) && (a_i[22:0] == 23'd0);
    b_inf = (eb == fisr_pkg::ExpMax) && (b_i[22:0] == 23'd0);
    a_big = a_i[30:0] >= b_i[30:0];
    spec_d = 1'b1;
    if (a_nan | b_nan | (a_inf & b_inf & (a_i[31] != b_i[31]))) begin
      sval_d = fisr_pkg::CanonNan;
    end else if (a_inf) begin
      sval_d = a_i;
    end else if (b_inf) begin
      sval_d = b_i;
    end else if ((a_i[30:0] == 31'd0) && (b_i[30:0] == 31'd0)) begin
      sval_d = {a_i[31] & b_i[31], 31'd0};
    end else begin
      spec_d = 1'b0;
      sval_d = 32'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (a_big) begin
        ml_q <= {(ea != 8'd0), a_i[22:0]};
        ms_q <= {(eb != 8'd0), b_i[22:0]};
        el_q <= (ea == 8'd0) ? 8'd1 : ea;
        d_q <= ((ea == 8'd0) ? 8'd1 : ea) - ((eb == 8'd0) ? 8'd1 : eb);
        sgn_q <= a_i[31];
      end else begin
        ml_q <= {(eb != 8'd0), b_i[22:0]};
        ms_q <= {(ea != 8'd0), a_i[22:0]};
        el_q <= (eb == 8'd0) ? 8'd1 : eb;
        d_q <= ((eb == 8'd0) ? 8'd1 : eb) - ((ea == 8'd0) ? 8'd1 : ea);
        sgn_q <= b_i[31];
      end
      sub_q <= a_i[31] ^ b_i[31];
      spec_q <= spec_d;
      sval_q <= sval_d;
    end
  end

  // stage 2: align the smaller operand, add or subtract
  logic [49:0] full;
  logic [26:0] al;
  logic [27:0] sum_d, sum_q, sum2_q;
  logic [7:0]  el2_q, el3_q;
  logic        sgn2_q, spec2_q, sgn3_q, spec3_q;
  logic [31:0] sval2_q, sval3_q;
  logic [5:0]  lz_q;

  always_comb begin
    full = {ms_q, 26'd0} >> d_q;
    if (d_q > 8'd26) begin
      al = {26'd0, ms_q != 24'd0};
    end else begin
      al = full[49:23] | {26'd0, full[22:0] != 23'd0};
    end
    if (sub_q) begin
      sum_d = {1'b0, ml_q, 3'b000} - {1'b0, al};
    end else begin
      sum_d = {1'b0, ml_q, 3'b000} + {1'b0, al};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      el2_q <= el_q;
      sgn2_q <= sgn_q;
      spec2_q <= spec_q;
      sval2_q <= sval_q;
    end
  end

  // stage 3: leading zero count
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lz_q <= fisr_pkg::lzc48({sum_q, 20'd0});
      sum2_q <= sum_q;
      el3_q <= el2_q;
      sgn3_q <= sgn2_q;
      spec3_q <= spec2_q;
      sval3_q <= sval2_q;
    end
  end

  // stage 4: normalize
  logic [26:0] n;
  logic [8:0]  e_n;
  logic [5:0]  k;
  logic [22:0] mant_q;
  logic [9:0]  fld_q;
  logic        g_q, st_q, zero_q, sgn4_q, spec4_q;
  logic [31:0] sval4_q;

  always_comb begin
    k = lz_q - 6'd1;
    if (sum2_q[27]) begin
      n = sum2_q[27:1] | {26'd0, sum2_q[0]};
      e_n = {1'b0, el3_q} + 9'd1;
    end else if ({2'd0, k} <= (el3_q - 8'd1)) begin
      n = sum2_q[26:0] << k;
      e_n = {1'b0, el3_q} - {3'd0, k};
    end else begin
      n = sum2_q[26:0] << (el3_q - 8'd1);
      e_n = 9'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mant_q <= n[25:3];
      g_q <= n[2];
      st_q <= n[1] | n[0];
      fld_q <= n[26] ? {1'b0, e_n} : 10'd0;
      zero_q <= sum2_q == 28'd0;
      sgn4_q <= sgn3_q;
      spec4_q <= spec3_q;
      sval4_q <= sval3_q;
    end
  end

  // stage 5: round and pack
  logic [31:0] s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= 32'd0;
    end else if (en_i) begin
      if (spec4_q) begin
        s_q <= sval4_q;
      end else if (zero_q) begin
        s_q <= 32'd0;
      end else begin
        s_q <= fisr_pkg::round_pack(sgn4_q, fld_q, mant_q, g_q, st_q);
      end
    end
  end

  assign s_o = s_q;

endmodule

@@ tb/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] PosInf = 32'h7F80_0000;
  localparam logic [31:0] NegInf = 32'hFF80_0000;
  localparam int unsigned RandomItems = 1300;
  localparam int unsigned LongHold = 200;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned WatchdogLimit = 2000;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        stall_o;
  logic [31:0] value_bits_i;
  logic        valid_o;
  logic        stall_i;
  logic [31:0] result_bits_o;

  // Expected result patterns, oldest first.
  logic [31:0] rsqrt_q[$];

  int unsigned error_count;
  int unsigned beats_in;
  int unsigned beats_out;
  int unsigned idle_cycles;
  bit          no_idle;
  bit          hold_req;

  fast_inverse_sqrt_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .value_bits_i (value_bits_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .result_bits_o(result_bits_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // ---------------------------------------------------------------------
  // binary32 arithmetic, round to nearest even, subnormals kept.
  // A magnitude is carried as mant * 2^exp2 until it is rounded and packed.
  // ---------------------------------------------------------------------
  function automatic bit is_nan(input logic [31:0] a);
    return (a[30:23] == fisr_pkg::ExpMax) && (a[22:0] != 23'd0);
  endfunction

  function automatic bit is_inf(input logic [31:0] a);
    return (a[30:23] == fisr_pkg::ExpMax) && (a[22:0] == 23'd0);
  endfunction

  function automatic void split_fp(input logic [31:0] a, output logic [127:0] mant,
                                   output int exp2);
    if (a[30:23] == 8'd0) begin
      mant = 128'(a[22:0]);
      exp2 = -149;
    end else begin
      mant = 128'({1'b1, a[22:0]});
      exp2 = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] round_fp(input bit sgn, input logic [127:0] mant,
                                           input int exp2);
    int          msb;
    int          sh;
    int          q;
    logic [127:0] r;
    logic [127:0] rem;
    bit          g;
    bit          st;
    if (mant == 128'd0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 128; i++) if (mant[i]) msb = i;
    // Keep 24 significant bits, but never go below the subnormal quantum.
    sh = msb - 23;
    if (sh < -149 - exp2) sh = -149 - exp2;
    if (sh >= 128) return {sgn, 31'd0};
    if (sh > 0) begin
      r = mant >> sh;
      g = mant[sh-1];
      rem = mant & ((128'd1 << (sh - 1)) - 128'd1);
      st = (rem != 128'd0);
      if (g && (st || r[0])) r = r + 128'd1;
    end else begin
      r = mant << (-sh);
    end
    q = exp2 + sh;
    if (r == (128'd1 << 24)) begin
      r = r >> 1;
      q++;
    end
    if (r < (128'd1 << 23)) return {sgn, 8'd0, r[22:0]};
    if (q + 150 >= 255) return {sgn, fisr_pkg::ExpMax, 23'd0};
    return {sgn, 8'(q + 150), r[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
    bit          sgn;
    logic [127:0] ma;
    logic [127:0] mb;
    int          ea;
    int          eb;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CanonNan;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return fisr_pkg::CanonNan;
      return {sgn, fisr_pkg::ExpMax, 23'd0};
    end
    split_fp(a, ma, ea);
    split_fp(b, mb, eb);
    return round_fp(sgn, ma * mb, ea + eb);
  endfunction

  function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] m_big;
    logic [127:0] m_sml;
    int          ea;
    int          eb;
    int          e_big;
    int          e_sml;
    int          e_sum;
    bit          s_big;
    bit          s_sml;
    if (is_nan(a) || is_nan(b)) return fisr_pkg::CanonNan;
    if (is_inf(a) && is_inf(b)) return (a[31] != b[31]) ? fisr_pkg::CanonNan : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
    split_fp(a, ma, ea);
    split_fp(b, mb, eb);
    if (ea >= eb) begin
      m_big = ma; e_big = ea; s_big = a[31];
      m_sml = mb; e_sml = eb; s_sml = b[31];
    end else begin
      m_big = mb; e_big = eb; s_big = b[31];
      m_sml = ma; e_sml = ea; s_sml = a[31];
    end
    // A far smaller operand only matters as a sticky bit below the round point.
    if (e_big - e_sml > 40) begin
      m_big = m_big << 40;
      m_sml = (m_sml != 128'd0) ? 128'd1 : 128'd0;
      e_sum = e_big - 40;
    end else begin
      m_big = m_big << (e_big - e_sml);
      e_sum = e_sml;
    end
    if (s_big == s_sml) return round_fp(s_big, m_big + m_sml, e_sum);
    if (m_big == m_sml) return 32'd0;
    if (m_big > m_sml) return round_fp(s_big, m_big - m_sml, e_sum);
    return round_fp(s_sml, m_sml - m_big, e_sum);
  endfunction

  // Seed from the magic constant, then one Newton step.
  function automatic logic [31:0] predict_rsqrt(input logic [31:0] x);
    logic [31:0] seed;
    logic [31:0] half;
    logic [31:0] t;
    logic [31:0] r;
    seed = fisr_pkg::MagicSeed - {x[31], x[31:1]};
    half = fp_mul(x, fisr_pkg::FpHalf);
    t = fp_mul(half, seed);
    t = fp_mul(t, seed);
    t = fp_add(fisr_pkg::FpThreeHalves, {~t[31], t[30:0]});
    r = fp_mul(seed, t);
    return is_nan(r) ? fisr_pkg::CanonNan : r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed table: expected value typed in only for the obvious rows.
  // ---------------------------------------------------------------------
  typedef struct packed {
    logic [31:0] value;
    bit          typed;
    logic [31:0] result;
  } dir_row_t;

  localparam int DirRows = 22;
  dir_row_t dir_table[DirRows] = '{
    '{32'h0000_0000, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 32'h0},
    '{32'h7F80_0000, 1'b1, NegInf},     // inf * 0.5 stays inf, 1.5 - inf goes -inf
    '{32'hFF80_0000, 1'b1, PosInf},
    '{32'h7FC0_0000, 1'b1, fisr_pkg::CanonNan},
    '{32'hFFFF_FFFF, 1'b1, fisr_pkg::CanonNan},
    '{32'h7F80_0001, 1'b1, fisr_pkg::CanonNan},
    '{32'hFFC0_0001, 1'b1, fisr_pkg::CanonNan},
    '{32'h0000_0001, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 32'h0},
    '{32'h007F_FFFF, 1'b0, 32'h0},
    '{32'h807F_FFFF, 1'b0, 32'h0},
    '{32'h0080_0000, 1'b0, 32'h0},
    '{32'h7F7F_FFFF, 1'b0, 32'h0},
    '{32'hFF7F_FFFF, 1'b0, 32'h0},
    '{32'h3F80_0000, 1'b0, 32'h0},
    '{32'h4080_0000, 1'b0, 32'h0},
    '{32'h3E80_0000, 1'b0, 32'h0},
    '{32'hBF80_0000, 1'b0, 32'h0},
    '{32'hC080_0000, 1'b0, 32'h0},
    '{32'h5F37_59DF, 1'b0, 32'h0},
    '{32'h2AAA_AAAA, 1'b0, 32'h0}
  };

  function automatic logic [31:0] random_operand();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: v = {1'b0, 8'($urandom_range(1, 254)), 23'($urandom)};
      5, 6:          v = $urandom;
      7:             v = {1'($urandom), 8'd0, 23'($urandom)};
      8:             v = {1'($urandom), ($urandom_range(0, 1) != 0) ?
                          8'($urandom_range(1, 3)) : 8'($urandom_range(250, 254)),
                          23'($urandom)};
      default:       v = {1'($urandom), fisr_pkg::ExpMax, ($urandom_range(0, 1) != 0) ?
                          23'd0 : 23'($urandom)};
    endcase
    return v;
  endfunction

  // Offer one beat after a random gap (none while no_idle is set); hold it
  // until accepted and record the expected result at the accepting edge.
  task automatic send_beat(input logic [31:0] v, input bit typed, input logic [31:0] res);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i      <= 1'b1;
    value_bits_i <= v;
    forever begin
      @(posedge clk_i);
      if (!stall_o) break;
    end
    rsqrt_q.push_back(typed ? res : predict_rsqrt(v));
    beats_in++;
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (rsqrt_q.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random stalls per beat unless no_idle, plus one long hold on request.
  // ---------------------------------------------------------------------
  initial begin
    int unsigned n;
    stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        stall_i <= 1'b1;
        repeat (LongHold) @(posedge clk_i);
        hold_req = 1'b0;
      end
      n = no_idle ? 0 : $urandom_range(0, 4);
      if (n > 0) begin
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      forever begin
        @(posedge clk_i);
        if (valid_o || hold_req) break;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output checker and watchdog.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni) begin
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (valid_o && !stall_i) begin
        beats_out++;
        if (rsqrt_q.size() == 0) begin
          $display("%0t: unexpected result beat %h", $realtime, result_bits_o);
          error_count++;
        end else begin
          want = rsqrt_q.pop_front();
          if (result_bits_o !== want) begin
            $display("%0t: result_bits mismatch, expected %h actual %h",
                     $realtime, want, result_bits_o);
            error_count++;
          end
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: watchdog expired with %0d results pending", $realtime,
                 rsqrt_q.size());
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    error_count  = 0;
    beats_in     = 0;
    beats_out    = 0;
    idle_cycles  = 0;
    no_idle      = 1'b0;
    hold_req     = 1'b0;
    valid_i      = 1'b0;
    value_bits_i = 32'd0;
    rst_ni       = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table: specials, extremes, signs, subnormals.
    for (int i = 0; i < DirRows; i++)
      send_beat(dir_table[i].value, dir_table[i].typed, dir_table[i].result);

    // Back to back against a long receiver hold: fill the pipe, see stall_o.
    no_idle  = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 60; i++) send_beat(random_operand(), 1'b0, 32'd0);
    no_idle = 1'b0;

    // Sender pause until everything is out.
    wait_drained();
    repeat (5) @(posedge clk_i);

    for (int i = 0; i < RandomItems; i++) begin
      // Alternate random idling with stretches of full rate.
      if (i % 200 == 100) no_idle = 1'b1;
      if (i % 200 == 150) no_idle = 1'b0;
      send_beat(random_operand(), 1'b0, 32'd0);
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d operands in, %0d results out: specials, subnormals, negatives,",
             beats_in, beats_out);
    $display("random normals, full-rate bursts and a long output hold");
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
